// ----- rtl/blt_pkg.sv -----
// Shared widths, constants and register indexes for the battery level tracker.
// No dependencies; every other file imports this package.
`default_nettype none

package blt_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int PCT_W       = 7;
    localparam int NUM_W       = SAMPLE_BITS + PCT_W;
    localparam int CNT_W       = $clog2(NUM_W + 1);
    localparam int IDX_W       = 2;

    localparam logic [PCT_W-1:0] PCT_SCALE = PCT_W'(100);

    localparam logic [SAMPLE_BITS-1:0] RISE_MARGIN_RST = SAMPLE_BITS'(100);
    localparam logic [SAMPLE_BITS-1:0] EMPTY_COUNT_RST = SAMPLE_BITS'(2000);
    localparam logic [SAMPLE_BITS-1:0] FULL_COUNT_RST  = SAMPLE_BITS'(3000);

    localparam logic [IDX_W-1:0] REG_RISE_MARGIN = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_EMPTY_COUNT = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_FULL_COUNT  = IDX_W'(2);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] rise_margin;
        logic [SAMPLE_BITS-1:0] empty_count;
        logic [SAMPLE_BITS-1:0] full_count;
    } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/blt_track.sv -----
// Hysteresis level register with clamping to the empty and full counts.
// Depends on blt_pkg.
`default_nettype none

module blt_track (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load,
    input  wire logic [blt_pkg::SAMPLE_BITS-1:0] sample,
    input  wire blt_pkg::cfg_t                  cfg,
    output logic      [blt_pkg::SAMPLE_BITS-1:0] level
);
    import blt_pkg::*;

    logic [SAMPLE_BITS-1:0] level_reg;
    logic [SAMPLE_BITS-1:0] level_next;
    logic [SAMPLE_BITS:0]   rise_limit;

    assign rise_limit = {1'b0, level_reg} + {1'b0, cfg.rise_margin};

    always_comb
    begin
        level_next = level_reg;
        if ({1'b0, sample} > rise_limit)
        begin
            level_next = sample;
        end
        if (sample < level_next)
        begin
            level_next = sample;
        end
        if (sample < cfg.empty_count)
        begin
            level_next = cfg.empty_count;
        end
        if (sample > cfg.full_count)
        begin
            level_next = cfg.full_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else if (load)
        begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

// ----- rtl/blt_div.sv -----
// Bit-serial restoring divider: one numerator bit enters the remainder per cycle.
// Depends on blt_pkg; the quotient is only valid when it is known to fit PCT_W bits.
`default_nettype none

module blt_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [blt_pkg::NUM_W-1:0]       num,
    input  wire logic [blt_pkg::SAMPLE_BITS-1:0] den,
    output logic                                done,
    output logic      [blt_pkg::PCT_W-1:0]       quot
);
    import blt_pkg::*;

    logic [NUM_W-1:0]       num_reg,  num_next;
    logic [SAMPLE_BITS-1:0] rem_reg,  rem_next;
    logic [PCT_W-1:0]       quot_reg, quot_next;
    logic [CNT_W-1:0]       cnt_reg,  cnt_next;
    logic                   done_reg, done_next;
    logic [SAMPLE_BITS:0]   shifted;
    logic [SAMPLE_BITS:0]   diff;
    logic                   fits;

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den};
    assign fits    = shifted >= {1'b0, den};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            rem_next  = '0;
            quot_next = '0;
            cnt_next  = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            rem_next  = fits ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
            quot_next = {quot_reg[PCT_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ----- rtl/battery_level_tracker.sv -----
// Top level of the battery level tracker: configuration registers, sequencer,
// output register. Depends on blt_pkg, blt_track and blt_div.
`default_nettype none

// One sample word is taken while the block is idle and no configuration word is
// offered. Its result word is formed by the level update, the scaling by 100, the
// bit-serial divider over the NUM_W numerator bits and a final output step. When
// the percentage is 0 or saturated at 100 the divider is skipped. The next sample
// may enter only after the previous result is loaded, so the block does not take a
// new sample before it is through with the last one. The result waits in an output
// register, so the next sample may enter while it is still stalled; a later result
// that finds it still stalled waits for it to leave.
module battery_level_tracker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire logic [blt_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic      [blt_pkg::SAMPLE_BITS-1:0] tracked_level,
    output logic      [blt_pkg::PCT_W-1:0]       percent,
    output logic                                low_battery,
    output logic                                range_error,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [blt_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [blt_pkg::SAMPLE_BITS-1:0] cfg_data
);
    import blt_pkg::*;

    state_t                 state_reg, state_next;
    cfg_t                   cfg_reg;
    logic                   accept;
    logic                   out_load;
    logic [SAMPLE_BITS-1:0] level;
    logic                   low_reg;
    logic                   err_reg;
    logic [PCT_W-1:0]       pct_reg, pct_next;
    logic [SAMPLE_BITS-1:0] span;
    logic [SAMPLE_BITS-1:0] delta;
    logic [NUM_W-1:0]       num;
    logic                   zero_case;
    logic                   sat_case;
    logic                   div_start;
    logic                   div_done;
    logic [PCT_W-1:0]       div_quot;
    logic                   result_valid_reg;
    logic [SAMPLE_BITS-1:0] level_out_reg;
    logic [PCT_W-1:0]       pct_out_reg;
    logic                   low_out_reg;
    logic                   err_out_reg;

    assign sample_stall = (state_reg != ST_IDLE) || cfg_valid;
    assign accept       = sample_valid && !sample_stall;
    assign cfg_ready    = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise_margin <= RISE_MARGIN_RST;
            cfg_reg.empty_count <= EMPTY_COUNT_RST;
            cfg_reg.full_count  <= FULL_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RISE_MARGIN:
                begin
                    cfg_reg.rise_margin <= cfg_data;
                end
                REG_EMPTY_COUNT:
                begin
                    cfg_reg.empty_count <= cfg_data;
                end
                REG_FULL_COUNT:
                begin
                    cfg_reg.full_count <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    blt_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .sample (sample),
        .cfg    (cfg_reg),
        .level  (level)
    );

    assign span      = cfg_reg.full_count - cfg_reg.empty_count;
    assign delta     = level - cfg_reg.empty_count;
    assign num       = NUM_W'(delta) * NUM_W'(PCT_SCALE);
    assign zero_case = (cfg_reg.full_count <= cfg_reg.empty_count)
                       || (level <= cfg_reg.empty_count);
    assign sat_case  = (delta >= span);
    assign div_start = (state_reg == ST_PREP) && !zero_case && !sat_case;

    blt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (span),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_load = (state_reg == ST_OUT) && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next = state_reg;
        pct_next   = pct_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                priority if (zero_case)
                begin
                    pct_next   = '0;
                    state_next = ST_OUT;
                end
                else if (sat_case)
                begin
                    pct_next   = PCT_SCALE;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    pct_next   = div_quot;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pct_reg <= pct_next;
        if (accept)
        begin
            low_reg <= (sample < cfg_reg.empty_count);
        end
        if (state_reg == ST_PREP)
        begin
            err_reg <= (cfg_reg.full_count <= cfg_reg.empty_count);
        end
        if (out_load)
        begin
            level_out_reg <= level;
            pct_out_reg   <= pct_reg;
            low_out_reg   <= low_reg;
            err_out_reg   <= err_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign tracked_level = level_out_reg;
    assign percent       = pct_out_reg;
    assign low_battery   = low_out_reg;
    assign range_error   = err_out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (percent <= PCT_SCALE))
        else $error("Percentage word exceeds full scale.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && range_error) |-> (percent == '0))
        else $error("Nonzero percentage with a bad range.");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_PREP))
        else $error("Accepted sample did not start processing.");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("Divider finished outside the divide state.");

endmodule

`default_nettype wire
